/* sv/glpht_pkg.sv */
// glpht_pkg: shared types and constants of the guid linear-probe hash table
// depends on nothing; used by glpht_ctrl, glpht_dpath and the top level
`timescale 1ns / 1ps

package glpht_pkg;

	// table geometry: slot count is always a power of two
	localparam int SLOT_W      = 9;
	localparam int TABLE_SLOTS = 1 << SLOT_W;

	// owner ids
	localparam int OWNER_W     = 7;
	localparam int OWNER_LIMIT = 128;
	localparam int OWNER_CMP_W = 9;

	// field widths
	localparam int KIND_W     = 2;
	localparam int KEY_W      = 64;
	localparam int HANDLE_W   = 32;
	localparam int OUT_SLOT_W = 9;

	// operation codes carried in kind
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// result codes loaded into the output register
	localparam logic [1:0] RES_FAIL   = 2'd0;
	localparam logic [1:0] RES_INSERT = 2'd1;
	localparam logic [1:0] RES_HIT    = 2'd2;
	localparam logic [1:0] RES_CLEAR  = 2'd3;

	// one stored slot
	typedef struct packed {
		logic                valid;
		logic [KEY_W-1:0]    key_high;
		logic [KEY_W-1:0]    key_low;
		logic [HANDLE_W-1:0] handle;
		logic [OWNER_W-1:0]  owner;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;
		logic       hash;
		logic       step;
		logic       wr_entry;
		logic       sweep;
		logic       res_load;
		logic [1:0] res_code;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              owner_ok;
		logic              empty;
		logic              match;
		logic              wrap;
		logic              sweep_last;
		logic              out_free;
	} dp_stat_t;

endpackage

/* sv/glpht_ctrl.sv */
// glpht_ctrl: sequencer for insert, lookup and clear transactions
// depends on glpht_pkg; drives the command struct of glpht_dpath
`timescale 1ns / 1ps

module glpht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  glpht_pkg::dp_stat_t stat,
	output glpht_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_CLR   = 3'd5;
	localparam logic [2:0] ST_CDONE = 3'd6;
	localparam logic [2:0] ST_FAIL  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       is_ins;
	logic       is_lkp;
	logic       done;

	assign is_ins   = (stat.kind == glpht_pkg::KIND_INSERT);
	assign is_lkp   = (stat.kind == glpht_pkg::KIND_LOOKUP);
	assign in_stall = (state_q != ST_IDLE);

	// probe ends on an empty slot, a lookup match or a full circle
	assign done = stat.empty || (is_lkp && stat.match) || stat.wrap;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.res_code = glpht_pkg::RES_FAIL;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_HASH;
				end
			end
			ST_HASH: begin
				cmd.hash = 1'b1;
				if (stat.kind == glpht_pkg::KIND_CLEAR) begin
					state_d = ST_CLR;
				end else if (is_lkp || (is_ins && stat.owner_ok)) begin
					state_d = ST_PROBE;
				end else begin
					state_d = ST_FAIL;
				end
			end
			ST_PROBE: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (done) begin
					if (stat.out_free) begin
						cmd.res_load = 1'b1;
						state_d      = ST_IDLE;
						if (is_ins && stat.empty) begin
							cmd.wr_entry = 1'b1;
							cmd.res_code = glpht_pkg::RES_INSERT;
						end else if (is_lkp && !stat.empty && stat.match) begin
							cmd.res_code = glpht_pkg::RES_HIT;
						end
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_CLR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_CDONE;
				end
			end
			ST_CDONE: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_code = glpht_pkg::RES_CLEAR;
					state_d      = ST_IDLE;
				end
			end
			ST_FAIL: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// state register; reset starts the invalidation sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/glpht_dpath.sv */
// glpht_dpath: request registers, home-slot hash, slot memory and result register
// depends on glpht_pkg; commanded by glpht_ctrl
`timescale 1ns / 1ps

module glpht_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  glpht_pkg::dp_cmd_t                   cmd,
	output glpht_pkg::dp_stat_t                  stat,
	input  logic [glpht_pkg::KIND_W-1:0]         kind,
	input  logic [glpht_pkg::KEY_W-1:0]          key_high,
	input  logic [glpht_pkg::KEY_W-1:0]          key_low,
	input  logic [glpht_pkg::HANDLE_W-1:0]       handle_in,
	input  logic [glpht_pkg::OWNER_W-1:0]        owner_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 success,
	output logic [glpht_pkg::HANDLE_W-1:0]       handle_out,
	output logic [glpht_pkg::OUT_SLOT_W-1:0]     slot_out
);

	localparam int SW = glpht_pkg::SLOT_W;

	// captured request
	logic [glpht_pkg::KIND_W-1:0]   kind_q;
	logic [glpht_pkg::KEY_W-1:0]    key_high_q;
	logic [glpht_pkg::KEY_W-1:0]    key_low_q;
	logic [glpht_pkg::HANDLE_W-1:0] handle_q;
	logic [glpht_pkg::OWNER_W-1:0]  owner_q;

	// probe pointers and sweep counter
	logic [SW-1:0] start_q;
	logic [SW-1:0] cur_q;
	logic [SW-1:0] nxt;
	logic [SW-1:0] sweep_q;
	logic [15:0]   hash_sum;

	// slot memory
	glpht_pkg::entry_t mem [glpht_pkg::TABLE_SLOTS];
	glpht_pkg::entry_t rd_q;
	glpht_pkg::entry_t wr_data;
	logic [SW-1:0]     rd_addr;
	logic [SW-1:0]     wr_addr;
	logic              wr_en;

	// result register
	logic                           out_valid_q;
	logic                           success_q;
	logic [glpht_pkg::HANDLE_W-1:0] handle_out_q;
	logic [glpht_pkg::OUT_SLOT_W-1:0] slot_out_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q     <= kind;
			key_high_q <= key_high;
			key_low_q  <= key_low;
			handle_q   <= handle_in;
			owner_q    <= owner_in;
		end
	end

	// home slot: 16-bit wrapping sum of the eight key slices
	always_comb begin
		hash_sum = '0;
		for (int k = 0; k < 4; k++) begin
			hash_sum = hash_sum + key_high_q[16*k +: 16] + key_low_q[16*k +: 16];
		end
	end

	assign nxt = cur_q + SW'(1);

	// probe pointers
	always_ff @(posedge clk) begin
		if (cmd.hash) begin
			start_q <= hash_sum[SW-1:0];
			cur_q   <= hash_sum[SW-1:0];
		end else if (cmd.step) begin
			cur_q <= nxt;
		end
	end

	// sweep counter wraps back to zero after the last slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_q + SW'(1);
		end
	end

	// memory ports: read the slot being checked or the next one ahead
	assign rd_addr = cmd.step ? nxt : cur_q;
	assign wr_addr = cmd.sweep ? sweep_q : cur_q;
	assign wr_en   = cmd.sweep || cmd.wr_entry;

	always_comb begin
		wr_data = '0;
		if (!cmd.sweep) begin
			wr_data.valid    = 1'b1;
			wr_data.key_high = key_high_q;
			wr_data.key_low  = key_low_q;
			wr_data.handle   = handle_q;
			wr_data.owner    = owner_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// status toward the controller
	always_comb begin
		stat            = '0;
		stat.kind       = kind_q;
		stat.owner_ok   = (glpht_pkg::OWNER_CMP_W'(owner_q)
			< glpht_pkg::OWNER_CMP_W'(glpht_pkg::OWNER_LIMIT));
		stat.empty      = !rd_q.valid;
		stat.match      = (rd_q.key_high == key_high_q) && (rd_q.key_low == key_low_q);
		stat.wrap       = (nxt == start_q);
		stat.sweep_last = (sweep_q == {SW{1'b1}});
		stat.out_free   = !out_valid_q || !out_stall;
	end

	// output transaction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			success_q    <= 1'b0;
			handle_out_q <= '0;
			slot_out_q   <= '0;
			case (cmd.res_code)
				glpht_pkg::RES_INSERT: begin
					success_q  <= 1'b1;
					slot_out_q <= glpht_pkg::OUT_SLOT_W'(cur_q);
				end
				glpht_pkg::RES_HIT: begin
					success_q    <= 1'b1;
					handle_out_q <= rd_q.handle;
					slot_out_q   <= glpht_pkg::OUT_SLOT_W'(cur_q);
				end
				glpht_pkg::RES_CLEAR: begin
					success_q <= 1'b1;
				end
				default: begin
					success_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign handle_out = handle_out_q;
	assign slot_out   = slot_out_q;

endmodule

/* sv/guid_linear_probe_hash_table_core.sv */
// guid_linear_probe_hash_table_core: open-addressed table of 128-bit keys
// insert/lookup: accept, hash, first read, then one slot probed per cycle; the result is
// registered once the probe ends and the output register is free
// clear: one slot invalidated per cycle, then the result is registered once the output is free
// one transaction at a time; the single memory read port gives one probe per cycle
// reset: in_stall stays high while every one of the TABLE_SLOTS (512) slots is invalidated
`timescale 1ns / 1ps

module guid_linear_probe_hash_table_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [glpht_pkg::KIND_W-1:0]         kind,
	input  logic [glpht_pkg::KEY_W-1:0]          key_high,
	input  logic [glpht_pkg::KEY_W-1:0]          key_low,
	input  logic [glpht_pkg::HANDLE_W-1:0]       handle_in,
	input  logic [glpht_pkg::OWNER_W-1:0]        owner_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 success,
	output logic [glpht_pkg::HANDLE_W-1:0]       handle_out,
	output logic [glpht_pkg::OUT_SLOT_W-1:0]     slot_out
);

	glpht_pkg::dp_cmd_t  cmd;
	glpht_pkg::dp_stat_t stat;

	// sequencer
	glpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// slot memory and result path
	glpht_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.kind       (kind),
		.key_high   (key_high),
		.key_low    (key_low),
		.handle_in  (handle_in),
		.owner_in   (owner_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.success    (success),
		.handle_out (handle_out),
		.slot_out   (slot_out)
	);

endmodule
